/* sv/fwgf_pkg.sv */
`timescale 1ns / 1ps

package fwgf_pkg;

  localparam int DEPTH     = 16;
  localparam int ITEM_BITS = 32;
  localparam int WORD_BITS = 32;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W    = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [ITEM_BITS-1:0] item_t;
  typedef logic [WORD_BITS-1:0] word_t;

  localparam fill_t FULL_LEVEL = fill_t'(DEPTH);
  localparam ptr_t  LAST_SLOT  = ptr_t'(DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_READ = 3'b100
  } state_t;

  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    item_t wdata;
    logic  re;
    ptr_t  raddr;
  } ram_req_t;

  function automatic ptr_t next_ptr(input ptr_t p);
    ptr_t r;
    if (p == LAST_SLOT) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic item_t word_to_item(input word_t w);
    logic [63:0] tmp;
    tmp = 64'(w);
    return tmp[ITEM_BITS-1:0];
  endfunction

  function automatic word_t item_to_word(input item_t it);
    logic [63:0] tmp;
    tmp = 64'(it);
    return tmp[WORD_BITS-1:0];
  endfunction

endpackage

/* sv/fwgf_slot_ram.sv */
`timescale 1ns / 1ps

module fwgf_slot_ram (
  input  logic               clk,
  input  fwgf_pkg::ram_req_t req,
  output fwgf_pkg::item_t    rdata
);

  fwgf_pkg::item_t mem [fwgf_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* sv/fwgf_ctrl.sv */
`timescale 1ns / 1ps

module fwgf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         command,
  input  logic [31:0]        item_data,
  output logic               busy,
  output logic               done,
  output logic               success,
  output logic [31:0]        item_out,
  output logic [31:0]        dropped_count,
  output fwgf_pkg::ram_req_t ram_req,
  input  fwgf_pkg::item_t    ram_rdata
);

  fwgf_pkg::state_t              state;
  fwgf_pkg::ptr_t                head;
  fwgf_pkg::ptr_t                tail;
  fwgf_pkg::fill_t               fill;
  logic [fwgf_pkg::DEPTH-1:0]    live;
  logic [31:0]                   drops;
  logic                          accept;
  logic                          has_room;
  fwgf_pkg::cmd_t                cmd;

  assign cmd      = fwgf_pkg::cmd_t'(command);
  assign accept   = start && (state == fwgf_pkg::ST_IDLE);
  assign has_room = (fill < fwgf_pkg::FULL_LEVEL);
  assign busy     = (state != fwgf_pkg::ST_IDLE);
  assign dropped_count = drops;

  // The payload is written on the accepting edge of a push; it is read only
  // once the scan lands on a live slot, so the two never meet on one entry.
  always_comb begin
    ram_req.we    = accept && (cmd == fwgf_pkg::CMD_PUSH) && has_room;
    ram_req.waddr = tail;
    ram_req.wdata = fwgf_pkg::word_to_item(item_data);
    ram_req.re    = (state == fwgf_pkg::ST_SCAN) && (fill != '0) && live[head];
    ram_req.raddr = head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwgf_pkg::ST_IDLE;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
      live  <= '0;
      drops <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        fwgf_pkg::ST_IDLE: begin
          if (start) begin
            unique case (cmd)
              fwgf_pkg::CMD_PUSH: begin
                if (has_room) begin
                  live[tail] <= 1'b1;
                  tail       <= fwgf_pkg::next_ptr(tail);
                  fill       <= fill + fwgf_pkg::fill_t'(1);
                  success    <= 1'b1;
                end else begin
                  drops   <= drops + 32'd1;
                  success <= 1'b0;
                end
                item_out <= '0;
                done     <= 1'b1;
              end
              fwgf_pkg::CMD_POP: begin
                state <= fwgf_pkg::ST_SCAN;
              end
              fwgf_pkg::CMD_FLUSH: begin
                // Queued entries stay in place as stale slots.
                live     <= '0;
                success  <= 1'b1;
                item_out <= '0;
                done     <= 1'b1;
              end
              default: begin
                success  <= 1'b0;
                item_out <= '0;
                done     <= 1'b1;
              end
            endcase
          end
        end
        fwgf_pkg::ST_SCAN: begin
          if (fill == '0) begin
            success  <= 1'b0;
            item_out <= '0;
            done     <= 1'b1;
            state    <= fwgf_pkg::ST_IDLE;
          end else begin
            // Every visited slot leaves the queue, stale or not.
            live[head] <= 1'b0;
            head       <= fwgf_pkg::next_ptr(head);
            fill       <= fill - fwgf_pkg::fill_t'(1);
            if (live[head]) begin
              state <= fwgf_pkg::ST_READ;
            end
          end
        end
        fwgf_pkg::ST_READ: begin
          success  <= 1'b1;
          item_out <= fwgf_pkg::item_to_word(ram_rdata);
          done     <= 1'b1;
          state    <= fwgf_pkg::ST_IDLE;
        end
        default: begin
          state <= fwgf_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/fifo_with_generation_flush.sv */
`timescale 1ns / 1ps

// Bounded queue of 32-bit work items with a lazy flush.
// Commands enter on start/command/item_data and are taken when start is high
// and busy is low. Each command yields exactly one result beat, shown for one
// cycle with done high, on success, item_out and dropped_count.
// A push or a flush never raises busy: its beat appears in the next cycle,
// so a new command may be taken in that same cycle.
// A pop raises busy and walks the slot memory from the head, one slot per
// cycle, discarding stale entries. Its beat appears in the first cycle with
// busy low again. The payload memory has a single, registered read port.
// A flush only clears the per-slot live marks; stale entries keep their slots
// until a pop passes over them. A push into a full queue is dropped and
// counted in dropped_count, which wraps.
// Synchronous reset empties the queue and clears the counter at once; no
// clearing pass is needed. The receiver cannot stall, so each beat is taken
// in the cycle it is shown.
module fifo_with_generation_flush (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  command,
  input  logic [31:0] item_data,
  output logic        busy,
  output logic        done,
  output logic        success,
  output logic [31:0] item_out,
  output logic [31:0] dropped_count
);

  fwgf_pkg::ram_req_t ram_req;
  fwgf_pkg::item_t    ram_rdata;

  fwgf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .command       (command),
    .item_data     (item_data),
    .busy          (busy),
    .done          (done),
    .success       (success),
    .item_out      (item_out),
    .dropped_count (dropped_count),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata)
  );

  fwgf_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

/* sv/fwgf_checker.sv */
`timescale 1ns / 1ps

module fwgf_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic [1:0]  command,
  input logic [31:0] item_data,
  input logic        busy,
  input logic        done,
  input logic        success,
  input logic [31:0] item_out,
  input logic [31:0] dropped_count
);

  // A failed beat never carries a payload.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> (item_out == 32'd0))
    else $error("item_out not zero on a failed beat");

  // Push, flush and unused codes answer in the very next cycle.
  a_quick_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command != fwgf_pkg::CMD_POP)) |=> (done && !busy))
    else $error("single-cycle command gave no beat");

  // A pop always walks the memory under busy.
  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == fwgf_pkg::CMD_POP)) |=> (busy && !done))
    else $error("pop did not raise busy");

  // The drop counter only ever steps by one.
  a_drop_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((dropped_count == $past(dropped_count)) ||
                     (dropped_count == $past(dropped_count) + 32'd1)))
    else $error("dropped_count jumped");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!busy && !done && (dropped_count == 32'd0)))
    else $error("block not idle after reset");

endmodule

bind fifo_with_generation_flush fwgf_checker u_fwgf_checker (.*);

/* tb/sv/fifo_with_generation_flush_tb.sv */
`timescale 1ns / 1ps

module fifo_with_generation_flush_tb;
  import fwgf_pkg::*;

  // Command code with no operation behind it; the block must answer with a
  // failed beat and leave its state alone.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int BLOCK_ITEMS = 50;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = DEPTH + 24;

  typedef struct {
    logic  success;
    word_t item_out;
    word_t dropped_count;
  } queue_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  command = CMD_PUSH;
  logic [31:0] item_data = '0;
  logic        busy;
  logic        done;
  logic        success;
  logic [31:0] item_out;
  logic [31:0] dropped_count;

  // Shadow copy of the queue.
  item_t shadow_payload [DEPTH];
  logic  shadow_live [DEPTH];
  ptr_t  shadow_head;
  ptr_t  shadow_tail;
  fill_t shadow_fill;
  word_t shadow_drops;

  queue_beat_t expected_beats[$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  bit          idle_enabled = 1'b1;

  fifo_with_generation_flush u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .command       (command),
    .item_data     (item_data),
    .busy          (busy),
    .done          (done),
    .success       (success),
    .item_out      (item_out),
    .dropped_count (dropped_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic ptr_t slot_after(input ptr_t p);
    return ptr_t'((int'(p) + 1) % DEPTH);
  endfunction

  function automatic queue_beat_t apply_queue_command(input logic [1:0] op,
                                                      input word_t data);
    queue_beat_t beat;
    logic        found;
    beat.success  = 1'b0;
    beat.item_out = '0;
    found         = 1'b0;
    case (op)
      CMD_PUSH: begin
        if (shadow_fill < FULL_LEVEL) begin
          shadow_payload[shadow_tail] = item_t'(data);
          shadow_live[shadow_tail]    = 1'b1;
          shadow_tail                 = slot_after(shadow_tail);
          shadow_fill                 = shadow_fill + fill_t'(1);
          beat.success                = 1'b1;
        end else begin
          shadow_drops = shadow_drops + word_t'(1);
        end
      end
      CMD_POP: begin
        // Stale entries ahead of the first live one are thrown away.
        while (shadow_fill != '0 && !found) begin
          found                    = shadow_live[shadow_head];
          if (found) begin
            beat.success  = 1'b1;
            beat.item_out = word_t'(shadow_payload[shadow_head]);
          end
          shadow_live[shadow_head] = 1'b0;
          shadow_head              = slot_after(shadow_head);
          shadow_fill              = shadow_fill - fill_t'(1);
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < DEPTH; i++) begin
          shadow_live[i] = 1'b0;
        end
        beat.success = 1'b1;
      end
      default: begin
      end
    endcase
    beat.dropped_count = shadow_drops;
    return beat;
  endfunction

  // Called just after a rising edge; returns just after the edge that took the command.
  task automatic issue_command(input logic [1:0] op, input word_t data);
    start     <= 1'b1;
    command   <= op;
    item_data <= data;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    expected_beats.push_back(apply_queue_command(op, data));
  endtask

  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic test_basic_ops();
    issue_command(CMD_POP, 32'h0000_0000);
    issue_command(CMD_RESERVED, 32'hFFFF_FFFF);
    issue_command(CMD_PUSH, 32'h0000_0000);
    maybe_idle();
    issue_command(CMD_PUSH, 32'hFFFF_FFFF);
    issue_command(CMD_POP, 32'hFFFF_FFFF);
    issue_command(CMD_FLUSH, $urandom);
    maybe_idle();
    issue_command(CMD_PUSH, 32'hA5A5_5A5A);
    // The stale entry at the head must be skipped on the way to the live one.
    issue_command(CMD_POP, $urandom);
    issue_command(CMD_PUSH, 32'h5A5A_A5A5);
    issue_command(CMD_FLUSH, $urandom);
    maybe_idle();
    // Only stale entries left: they are all removed and the pop fails.
    issue_command(CMD_POP, $urandom);
    issue_command(CMD_POP, $urandom);
    issue_command(CMD_FLUSH, $urandom);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 2; i++) begin
      issue_command(CMD_PUSH, $urandom);
    end
    issue_command(CMD_RESERVED, $urandom);
    issue_command(CMD_FLUSH, $urandom);
    issue_command(CMD_PUSH, 32'h8000_0001);
    maybe_idle();
    issue_command(CMD_POP, $urandom);
    issue_command(CMD_POP, $urandom);
  endtask

  task automatic test_random_traffic(input int blocks, input bit with_idle);
    int          mix;
    int          roll;
    logic [1:0]  op;
    for (int b = 0; b < blocks; b++) begin
      // Each block leans towards filling, draining or neither.
      mix          = $urandom_range(0, 2);
      idle_enabled = with_idle && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        case (mix)
          0:       op = (roll < 75) ? CMD_PUSH : (roll < 92) ? CMD_POP :
                        (roll < 98) ? CMD_FLUSH : CMD_RESERVED;
          1:       op = (roll < 25) ? CMD_PUSH : (roll < 88) ? CMD_POP :
                        (roll < 96) ? CMD_FLUSH : CMD_RESERVED;
          default: op = (roll < 48) ? CMD_PUSH : (roll < 88) ? CMD_POP :
                        (roll < 96) ? CMD_FLUSH : CMD_RESERVED;
        endcase
        maybe_idle();
        issue_command(op, $urandom);
      end
    end
    idle_enabled = 1'b1;
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    while (expected_beats.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_beats
    queue_beat_t want;
    if (!rst && done === 1'b1) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no command outstanding");
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        if (success !== want.success) begin
          $error("success: expected %0d, actual %0d", want.success, success);
          error_count++;
        end
        if (item_out !== want.item_out) begin
          $error("item_out: expected %h, actual %h", want.item_out, item_out);
          error_count++;
        end
        if (dropped_count !== want.dropped_count) begin
          $error("dropped_count: expected %0d, actual %0d",
                 want.dropped_count, dropped_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("fifo_with_generation_flush: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_payload[i] = '0;
      shadow_live[i]    = 1'b0;
    end
    shadow_head  = '0;
    shadow_tail  = '0;
    shadow_fill  = '0;
    shadow_drops = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_overflow();
    test_random_traffic(9, 1'b1);
    test_drain_pause();
    test_random_traffic(6, 1'b1);
    test_random_traffic(3, 1'b0);

    start <= 1'b0;
    while (expected_beats.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("fifo_with_generation_flush: match");
    end else begin
      $display("fifo_with_generation_flush: mismatch");
    end
    $finish;
  end

endmodule
